### hw/rtl/i2c_register_transaction_master_top_defines.svh
// Assertion helpers used by the checker file.
`ifndef I2C_REGISTER_TRANSACTION_MASTER_TOP_DEFINES_SVH
`define I2C_REGISTER_TRANSACTION_MASTER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define I2CRTM_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define I2CRTM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/i2crtm_pkg.sv
// ----------------------------------------------------------------------------
// i2crtm_pkg
// Types, codes and helpers for the I2C register transaction master.
// ----------------------------------------------------------------------------
package i2crtm_pkg;

    typedef enum logic [1:0] {
        FUNC_NONE  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_PROBE = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_START  = 4'd1,
        PH_SADRW  = 4'd2,
        PH_AADRW  = 4'd3,
        PH_SREG   = 4'd4,
        PH_AREG   = 4'd5,
        PH_RSTART = 4'd6,
        PH_SADRR  = 4'd7,
        PH_AADRR  = 4'd8,
        PH_SDATA  = 4'd9,
        PH_ADATA  = 4'd10,
        PH_READ   = 4'd11,
        PH_MACK   = 4'd12,
        PH_STOP   = 4'd13
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] bit_index;
        logic [1:0] tick_in_bit;
        logic [7:0] shift_byte;
        logic [7:0] bytes_left;
        logic [6:0] saved_address;
        logic [7:0] saved_register;
        func_t      mode;
        logic       scl_out;
        logic       sda_out;
        logic       nack_seen;
    } seq_state_t;

    typedef struct packed {
        logic       data_taken;
        logic       rd_valid;
        logic [7:0] rd_data;
        logic       nack;
        logic       done_res;
        logic       busy_res;
        logic       sda_level;
        logic       scl_level;
    } result_t;

    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 16;

    // result bit positions inside m_tdata
    localparam int unsigned RB_SCL   = 0;
    localparam int unsigned RB_SDA   = 1;
    localparam int unsigned RB_BUSY  = 2;
    localparam int unsigned RB_DONE  = 3;
    localparam int unsigned RB_NACK  = 4;
    localparam int unsigned RB_RDV   = 13;
    localparam int unsigned RB_TAKEN = 14;

    localparam seq_state_t STATE_RESET = '{
        phase:          PH_IDLE,
        bit_index:      3'd0,
        tick_in_bit:    2'd0,
        shift_byte:     8'd0,
        bytes_left:     8'd0,
        saved_address:  7'd0,
        saved_register: 8'd0,
        mode:           FUNC_NONE,
        scl_out:        1'b1,
        sda_out:        1'b1,
        nack_seen:      1'b0
    };

    function automatic seq_state_t enter_phase(seq_state_t s, phase_t p);
        seq_state_t t;
        t = s;
        t.phase       = p;
        t.bit_index   = 3'd0;
        t.tick_in_bit = 2'd0;
        return t;
    endfunction

    // acknowledge phase that follows a byte send phase
    function automatic phase_t ack_phase_of(phase_t p);
        phase_t q;
        case (p)
            PH_SADRW: q = PH_AADRW;
            PH_SREG:  q = PH_AREG;
            PH_SADRR: q = PH_AADRR;
            default:  q = PH_ADATA;
        endcase
        return q;
    endfunction

endpackage

### hw/rtl/i2crtm_step.sv
// ----------------------------------------------------------------------------
// i2crtm_step
// One bus tick of the transaction sequencer: next state and tick result.
// ----------------------------------------------------------------------------
module i2crtm_step (
    input  i2crtm_pkg::seq_state_t cur,
    input  logic [1:0]             func,
    input  logic [6:0]             dev_addr,
    input  logic [7:0]             reg_addr,
    input  logic [7:0]             byte_count,
    input  logic [7:0]             wr_data,
    input  logic                   sda_in,
    output i2crtm_pkg::seq_state_t nxt,
    output i2crtm_pkg::result_t    res
);
    import i2crtm_pkg::*;

    always_comb
    begin
        seq_state_t n;
        result_t    r;
        n = cur;
        r = '0;

        if (n.phase == PH_IDLE)
        begin
            n.scl_out = 1'b1;
            n.sda_out = 1'b1;
            if (func != FUNC_NONE)
            begin
                n.mode           = func_t'(func);
                n.saved_address  = dev_addr;
                n.saved_register = reg_addr;
                n.bytes_left     = byte_count;
                n.nack_seen      = 1'b0;
                n            = enter_phase(n, PH_START);
            end
        end

        case (n.phase)
            PH_START, PH_RSTART:
            begin
                if (n.tick_in_bit == 2'd0)
                begin
                    n.scl_out     = 1'b1;
                    n.sda_out     = 1'b1;
                    n.tick_in_bit = 2'd1;
                end
                else if (n.tick_in_bit == 2'd1)
                begin
                    n.sda_out     = 1'b0;
                    n.tick_in_bit = 2'd2;
                end
                else
                begin
                    n.scl_out = 1'b0;
                    n = enter_phase(n, (n.phase == PH_START) ? PH_SADRW : PH_SADRR);
                end
            end
            PH_SADRW, PH_SREG, PH_SADRR, PH_SDATA:
            begin
                if (n.tick_in_bit == 2'd0)
                begin
                    if (n.bit_index == 3'd0)
                    begin
                        case (n.phase)
                            PH_SADRW: n.shift_byte = {n.saved_address, 1'b0};
                            PH_SREG:  n.shift_byte = n.saved_register;
                            PH_SADRR: n.shift_byte = {n.saved_address, 1'b1};
                            default:
                            begin
                                n.shift_byte = wr_data;
                                r.data_taken = 1'b1;
                            end
                        endcase
                    end
                    n.scl_out     = 1'b0;
                    n.sda_out     = n.shift_byte[7];
                    n.tick_in_bit = 2'd1;
                end
                else if (n.tick_in_bit == 2'd1)
                begin
                    n.scl_out     = 1'b1;
                    n.tick_in_bit = 2'd2;
                end
                else
                begin
                    n.scl_out    = 1'b0;
                    n.shift_byte = {n.shift_byte[6:0], 1'b0};
                    if (n.bit_index == 3'd7)
                    begin
                        n.sda_out = 1'b1;
                        n = enter_phase(n, ack_phase_of(n.phase));
                    end
                    else
                    begin
                        n.bit_index   = n.bit_index + 3'd1;
                        n.tick_in_bit = 2'd0;
                    end
                end
            end
            PH_AADRW, PH_AREG, PH_AADRR, PH_ADATA:
            begin
                n.sda_out = 1'b1;
                if (n.tick_in_bit == 2'd0)
                begin
                    n.scl_out     = 1'b0;
                    n.tick_in_bit = 2'd1;
                end
                else if (n.tick_in_bit == 2'd1)
                begin
                    n.scl_out     = 1'b1;
                    n.nack_seen   = sda_in;
                    n.tick_in_bit = 2'd2;
                end
                else
                begin
                    n.scl_out = 1'b0;
                    if (n.nack_seen)
                        n = enter_phase(n, PH_STOP);
                    else
                    begin
                        case (n.phase)
                            PH_AADRW:
                                n = enter_phase(n, (n.mode == FUNC_PROBE) ? PH_STOP : PH_SREG);
                            PH_AREG:
                            begin
                                if (n.mode == FUNC_READ)
                                    n = enter_phase(n, PH_RSTART);
                                else
                                    n = enter_phase(n,
                                        (n.bytes_left != 8'd0) ? PH_SDATA : PH_STOP);
                            end
                            PH_AADRR:
                                n = enter_phase(n,
                                    (n.bytes_left != 8'd0) ? PH_READ : PH_STOP);
                            default:
                            begin
                                n.bytes_left = n.bytes_left - 8'd1;
                                n = enter_phase(n,
                                    (n.bytes_left != 8'd0) ? PH_SDATA : PH_STOP);
                            end
                        endcase
                    end
                end
            end
            PH_READ:
            begin
                n.sda_out = 1'b1;
                if (n.tick_in_bit == 2'd0)
                begin
                    n.scl_out     = 1'b1;
                    n.shift_byte  = {n.shift_byte[6:0], sda_in};
                    n.tick_in_bit = 2'd1;
                end
                else
                begin
                    n.scl_out = 1'b0;
                    if (n.bit_index == 3'd7)
                    begin
                        r.rd_valid = 1'b1;
                        r.rd_data  = n.shift_byte;
                        n = enter_phase(n, PH_MACK);
                    end
                    else
                    begin
                        n.bit_index   = n.bit_index + 3'd1;
                        n.tick_in_bit = 2'd0;
                    end
                end
            end
            PH_MACK:
            begin
                // last byte gets NACK, the others ACK
                n.sda_out = (n.bytes_left <= 8'd1);
                if (n.tick_in_bit == 2'd0)
                begin
                    n.scl_out     = 1'b0;
                    n.tick_in_bit = 2'd1;
                end
                else if (n.tick_in_bit == 2'd1)
                begin
                    n.scl_out     = 1'b1;
                    n.tick_in_bit = 2'd2;
                end
                else
                begin
                    n.scl_out    = 1'b0;
                    n.bytes_left = n.bytes_left - 8'd1;
                    n = enter_phase(n, (n.bytes_left != 8'd0) ? PH_READ : PH_STOP);
                end
            end
            PH_STOP:
            begin
                n.scl_out = 1'b1;
                if (n.tick_in_bit == 2'd0)
                begin
                    n.sda_out     = 1'b0;
                    n.tick_in_bit = 2'd1;
                end
                else
                begin
                    n.sda_out  = 1'b1;
                    r.done_res = 1'b1;
                    r.nack     = n.nack_seen;
                    n = enter_phase(n, PH_IDLE);
                end
            end
            default:
            begin
                n = n;
            end
        endcase

        r.scl_level = n.scl_out;
        r.sda_level = n.sda_out;
        r.busy_res  = (n.phase != PH_IDLE);

        nxt = n;
        res = r;
    end

endmodule

### hw/rtl/i2c_register_transaction_master_top.sv
// ----------------------------------------------------------------------------
// i2c_register_transaction_master_top
// Pin-level I2C master for register write, register read and address probe.
// ----------------------------------------------------------------------------
//  channel | dir | tuser        | tdata
//  s_*     | in  | func         | dev_addr, reg_addr, byte_count, wr_data, sda_in
//  m_*     | out | -            | scl/sda levels, busy, done, nack, rd_data, ...
//
//  One item is one bus tick; one result item per input item.
//  An item is taken every cycle while s_tready is high; its result lands in
//  the output register in the next cycle. The sequencer state advances only
//  on an accepted item. When the output register is full and not drained,
//  s_tready drops. Reset releases both bus lines and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module i2c_register_transaction_master_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [6:0] dev_addr, [14:7] reg_addr, [22:15] byte_count, [30:23] wr_data,
    // [31] sda_in
    input  logic [31:0] s_tdata,
    // [1:0] func
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res, [4] nack,
    // [12:5] rd_data, [13] rd_valid, [14] data_taken, [15] zero
    output logic [15:0] m_tdata
);
    import i2crtm_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    res;
    result_t    res_reg;
    logic       m_tvalid_reg;
    logic       accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    i2crtm_step u_step (
        .cur        (state_reg),
        .func       (s_tuser),
        .dev_addr   (s_tdata[6:0]),
        .reg_addr   (s_tdata[14:7]),
        .byte_count (s_tdata[22:15]),
        .wr_data    (s_tdata[30:23]),
        .sda_in     (s_tdata[31]),
        .nxt        (state_next),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= STATE_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_reg};

endmodule

### hw/rtl/i2crtm_checker.sv
// ----------------------------------------------------------------------------
// i2crtm_checker
// Port-level checks on the result stream of the I2C transaction master.
// ----------------------------------------------------------------------------
`include "i2c_register_transaction_master_top_defines.svh"

module i2crtm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import i2crtm_pkg::*;

    `I2CRTM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")
    `I2CRTM_ASSERT_NOW(a_done_idle, m_tvalid && m_tdata[RB_DONE], !m_tdata[RB_BUSY] && m_tdata[RB_SCL] && m_tdata[RB_SDA], "done without a released bus")
    `I2CRTM_ASSERT_NOW(a_nack_done, m_tvalid && m_tdata[RB_NACK], m_tdata[RB_DONE], "nack outside done")
    `I2CRTM_ASSERT_NOW(a_rdv_busy, m_tvalid && (m_tdata[RB_RDV] || m_tdata[RB_TAKEN]), m_tdata[RB_BUSY] && !m_tdata[RB_SCL], "byte event off the bus cycle")

endmodule

bind i2c_register_transaction_master_top i2crtm_checker u_i2crtm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### sim/tb_i2c_register_transaction_master_top.sv
// ----------------------------------------------------------------------------
// tb_i2c_register_transaction_master_top
// Self-checking bench for the pin-level I2C register master. Register writes,
// register reads and address probes are run tick by tick, with the bus
// acknowledge driven from the bench. Every result item is checked against a
// tick-accurate model of the sequencer, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_i2c_register_transaction_master_top;
    import i2crtm_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [6:0] dev_addr, [14:7] reg_addr, [22:15] byte_count, [30:23] wr_data,
    // [31] sda_in
    logic [31:0] s_tdata = '0;
    // [1:0] func
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res, [4] nack,
    // [12:5] rd_data, [13] rd_valid, [14] data_taken, [15] zero
    logic [15:0] m_tdata;

    i2c_register_transaction_master_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("tb_i2c_register_transaction_master_top NOT OK");
        $finish;
    end

    // bus sequencer mirror and expected pin levels
    seq_state_t     seq = STATE_RESET;
    result_t        pin_q[$];
    logic [7:0]     write_bytes[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_left      = 0;

    int errors       = 0;
    int ticks_sent   = 0;
    int xfers_run    = 0;
    int dones_seen   = 0;
    int nacks_seen   = 0;
    int bytes_read   = 0;
    int input_stalls = 0;

    function automatic void goto_phase(phase_t p);
        seq.phase       = p;
        seq.bit_index   = 3'd0;
        seq.tick_in_bit = 2'd0;
    endfunction

    function automatic void ack_done();
        if (seq.nack_seen) begin
            goto_phase(PH_STOP);
            return;
        end
        case (seq.phase)
            PH_AADRW:
                if (seq.mode == FUNC_PROBE) goto_phase(PH_STOP);
                else goto_phase(PH_SREG);
            PH_AREG:
                if (seq.mode == FUNC_READ) goto_phase(PH_RSTART);
                else if (seq.bytes_left != 8'd0) goto_phase(PH_SDATA);
                else goto_phase(PH_STOP);
            PH_AADRR:
                if (seq.bytes_left != 8'd0) goto_phase(PH_READ);
                else goto_phase(PH_STOP);
            default:
            begin
                seq.bytes_left = seq.bytes_left - 8'd1;
                if (seq.bytes_left != 8'd0) goto_phase(PH_SDATA);
                else goto_phase(PH_STOP);
            end
        endcase
    endfunction

    // one bus tick of the sequencer; returns the pin levels and flags after it
    function automatic result_t bus_tick(func_t fn, logic [6:0] dev, logic [7:0] regp,
                                         logic [7:0] cnt, logic [7:0] wd, logic sda);
        result_t r;
        r = '0;
        if (seq.phase == PH_IDLE) begin
            seq.scl_out = 1'b1;
            seq.sda_out = 1'b1;
            if (fn != FUNC_NONE) begin
                seq.mode           = fn;
                seq.saved_address  = dev;
                seq.saved_register = regp;
                seq.bytes_left     = cnt;
                seq.nack_seen      = 1'b0;
                goto_phase(PH_START);
            end
        end

        case (seq.phase)
            PH_START, PH_RSTART:
                if (seq.tick_in_bit == 2'd0) begin
                    seq.scl_out     = 1'b1;
                    seq.sda_out     = 1'b1;
                    seq.tick_in_bit = 2'd1;
                end else if (seq.tick_in_bit == 2'd1) begin
                    seq.sda_out     = 1'b0;
                    seq.tick_in_bit = 2'd2;
                end else begin
                    seq.scl_out = 1'b0;
                    if (seq.phase == PH_START) goto_phase(PH_SADRW);
                    else goto_phase(PH_SADRR);
                end
            PH_SADRW, PH_SREG, PH_SADRR, PH_SDATA:
                if (seq.tick_in_bit == 2'd0) begin
                    if (seq.bit_index == 3'd0) begin
                        case (seq.phase)
                            PH_SADRW: seq.shift_byte = {seq.saved_address, 1'b0};
                            PH_SREG:  seq.shift_byte = seq.saved_register;
                            PH_SADRR: seq.shift_byte = {seq.saved_address, 1'b1};
                            default:
                            begin
                                seq.shift_byte = wd;
                                r.data_taken   = 1'b1;
                            end
                        endcase
                    end
                    seq.scl_out     = 1'b0;
                    seq.sda_out     = seq.shift_byte[7];
                    seq.tick_in_bit = 2'd1;
                end else if (seq.tick_in_bit == 2'd1) begin
                    seq.scl_out     = 1'b1;
                    seq.tick_in_bit = 2'd2;
                end else begin
                    seq.scl_out    = 1'b0;
                    seq.shift_byte = {seq.shift_byte[6:0], 1'b0};
                    if (seq.bit_index == 3'd7) begin
                        // release SDA for the acknowledge slot
                        seq.sda_out = 1'b1;
                        goto_phase(phase_t'(seq.phase + 4'd1));
                    end else begin
                        seq.bit_index   = seq.bit_index + 3'd1;
                        seq.tick_in_bit = 2'd0;
                    end
                end
            PH_AADRW, PH_AREG, PH_AADRR, PH_ADATA:
            begin
                seq.sda_out = 1'b1;
                if (seq.tick_in_bit == 2'd0) begin
                    seq.scl_out     = 1'b0;
                    seq.tick_in_bit = 2'd1;
                end else if (seq.tick_in_bit == 2'd1) begin
                    seq.scl_out     = 1'b1;
                    seq.nack_seen   = sda;
                    seq.tick_in_bit = 2'd2;
                end else begin
                    seq.scl_out = 1'b0;
                    ack_done();
                end
            end
            PH_READ:
            begin
                seq.sda_out = 1'b1;
                if (seq.tick_in_bit == 2'd0) begin
                    seq.scl_out     = 1'b1;
                    seq.shift_byte  = {seq.shift_byte[6:0], sda};
                    seq.tick_in_bit = 2'd1;
                end else begin
                    seq.scl_out = 1'b0;
                    if (seq.bit_index == 3'd7) begin
                        r.rd_valid = 1'b1;
                        r.rd_data  = seq.shift_byte;
                        goto_phase(PH_MACK);
                    end else begin
                        seq.bit_index   = seq.bit_index + 3'd1;
                        seq.tick_in_bit = 2'd0;
                    end
                end
            end
            PH_MACK:
            begin
                // ACK every byte but the last
                seq.sda_out = (seq.bytes_left <= 8'd1);
                if (seq.tick_in_bit == 2'd0) begin
                    seq.scl_out     = 1'b0;
                    seq.tick_in_bit = 2'd1;
                end else if (seq.tick_in_bit == 2'd1) begin
                    seq.scl_out     = 1'b1;
                    seq.tick_in_bit = 2'd2;
                end else begin
                    seq.scl_out    = 1'b0;
                    seq.bytes_left = seq.bytes_left - 8'd1;
                    if (seq.bytes_left != 8'd0) goto_phase(PH_READ);
                    else goto_phase(PH_STOP);
                end
            end
            PH_STOP:
            begin
                seq.scl_out = 1'b1;
                if (seq.tick_in_bit == 2'd0) begin
                    seq.sda_out     = 1'b0;
                    seq.tick_in_bit = 2'd1;
                end else begin
                    seq.sda_out = 1'b1;
                    r.done_res  = 1'b1;
                    r.nack      = seq.nack_seen;
                    goto_phase(PH_IDLE);
                end
            end
            default: ;
        endcase

        r.scl_level = seq.scl_out;
        r.sda_level = seq.sda_out;
        r.busy_res  = (seq.phase != PH_IDLE);
        return r;
    endfunction

    task automatic send_tick(func_t fn, logic [6:0] dev, logic [7:0] regp,
                             logic [7:0] cnt, logic [7:0] wd, logic sda);
        pin_q.push_back(bus_tick(fn, dev, regp, cnt, wd, sda));
        @(negedge clk);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sda, wd, cnt, regp, dev};
        s_tuser  <= fn;
        do @(posedge clk); while (!s_tready);
    endtask

    // Runs one transaction to its stop. nack_at picks which acknowledge slot
    // (counted from the address) the target leaves high; -1 means none.
    // With noisy set, the ticks carry random requests that must be ignored.
    task automatic run_xfer(func_t fn, logic [6:0] dev, logic [7:0] regp,
                            logic [7:0] cnt, int nack_at, bit noisy);
        int    ack_no;
        logic  sda;
        logic  [7:0] wd;
        func_t tf;
        ack_no = 0;
        xfers_run++;
        send_tick(fn, dev, regp, cnt, 8'($urandom), 1'($urandom));
        ticks_sent++;
        while (seq.phase != PH_IDLE) begin
            sda = 1'($urandom);
            if ((seq.phase == PH_AADRW || seq.phase == PH_AREG || seq.phase == PH_AADRR ||
                 seq.phase == PH_ADATA) && seq.tick_in_bit == 2'd1) begin
                sda = (ack_no == nack_at);
                ack_no++;
            end
            wd = 8'($urandom);
            if (seq.phase == PH_SDATA && seq.tick_in_bit == 2'd0 && seq.bit_index == 3'd0 &&
                write_bytes.size() != 0)
                wd = write_bytes.pop_front();
            tf = noisy ? func_t'($urandom_range(3, 0)) : FUNC_NONE;
            send_tick(tf, 7'($urandom), 8'($urandom), 8'($urandom), wd, sda);
            ticks_sent++;
        end
        write_bytes.delete();
    endtask

    task automatic idle_ticks(int n);
        repeat (n) send_tick(FUNC_NONE, 7'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 1'($urandom));
    endtask

    // ---------------- tests ----------------

    task automatic test_idle_bus();
        idle_ticks(4);
    endtask

    task automatic test_probe();
        run_xfer(FUNC_PROBE, 7'h00, 8'h00, 8'h00, -1, 1'b0);
        run_xfer(FUNC_PROBE, 7'h7F, 8'hFF, 8'hFF, 0, 1'b0);
    endtask

    task automatic test_write();
        run_xfer(FUNC_WRITE, 7'h7F, 8'hFF, 8'd0, -1, 1'b0);
        write_bytes.push_back(8'hFF);
        write_bytes.push_back(8'h00);
        run_xfer(FUNC_WRITE, 7'h55, 8'h00, 8'd2, -1, 1'b0);
    endtask

    task automatic test_read();
        run_xfer(FUNC_READ, 7'h2A, 8'h80, 8'd0, -1, 1'b0);
        run_xfer(FUNC_READ, 7'h51, 8'h01, 8'd2, -1, 1'b0);
    endtask

    task automatic test_nack_abort();
        // full byte count, target refuses the first data byte
        run_xfer(FUNC_WRITE, 7'h3C, 8'hC3, 8'd255, 2, 1'b0);
        // full byte count, address with read bit refused
        run_xfer(FUNC_READ, 7'h66, 8'h99, 8'd255, 2, 1'b0);
    endtask

    task automatic test_request_while_busy();
        run_xfer(FUNC_WRITE, 7'h70, 8'h0F, 8'd1, -1, 1'b1);
    endtask

    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 1'b1;
        run_xfer(FUNC_PROBE, 7'h48, 8'h5A, 8'd3, -1, 1'b0);
    endtask

    // ---------------- result side ----------------

    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = 200;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
        end
    end

    always @(posedge clk) begin : result_check
        result_t got;
        result_t want;
        if (rst_n) begin
            if (s_tvalid && !s_tready)
                input_stalls++;
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[14:0]);
                if (pin_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result item %h", m_tdata);
                end else begin
                    want = pin_q.pop_front();
                    dones_seen += want.done_res;
                    nacks_seen += want.nack;
                    bytes_read += want.rd_valid;
                    if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
                        got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                        got.nack !== want.nack || got.rd_data !== want.rd_data ||
                        got.rd_valid !== want.rd_valid || got.data_taken !== want.data_taken ||
                        m_tdata[15] !== 1'b0) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp scl=%b sda=%b busy=%b done=%b nack=%b ",
                                      "rd=%h rdv=%b taken=%b | got scl=%b sda=%b busy=%b ",
                                      "done=%b nack=%b rd=%h rdv=%b taken=%b pad=%b"},
                                     want.scl_level, want.sda_level, want.busy_res,
                                     want.done_res, want.nack, want.rd_data, want.rd_valid,
                                     want.data_taken, got.scl_level, got.sda_level,
                                     got.busy_res, got.done_res, got.nack, got.rd_data,
                                     got.rd_valid, got.data_taken, m_tdata[15]);
                    end
                end
            end
        end
    end

    initial begin
        int guard;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no idling on either side
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_idle_bus();
        test_probe();
        test_write();

        // sender mostly idle
        src_idle_pct   = 85;
        sink_stall_pct = 0;
        test_read();

        // receiver mostly stalling
        src_idle_pct   = 0;
        sink_stall_pct = 85;
        test_nack_abort();

        // light idling on both sides
        src_idle_pct   = 18;
        sink_stall_pct = 18;
        test_request_while_busy();

        test_backpressure();

        @(negedge clk);
        s_tvalid       <= 1'b0;
        sink_stall_pct = 0;
        guard          = 0;
        while (pin_q.size() != 0 && guard < 10000) begin
            @(posedge clk);
            guard++;
        end
        if (pin_q.size() != 0) begin
            errors++;
            $display("%0d result items never arrived", pin_q.size());
        end
        repeat (5) @(posedge clk);

        $display("covered %0d transactions over %0d bus ticks: %0d stops, %0d refused acks,",
                 xfers_run, ticks_sent, dones_seen, nacks_seen);
        $display("%0d bytes read, input held off for %0d cycles; %0d errors",
                 bytes_read, input_stalls, errors);
        if (errors == 0)
            $display("tb_i2c_register_transaction_master_top OK");
        else
            $display("tb_i2c_register_transaction_master_top NOT OK");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/i2crtm_pkg.sv
hw/rtl/i2crtm_step.sv
hw/rtl/i2c_register_transaction_master_top.sv
hw/rtl/i2crtm_checker.sv
sim/tb_i2c_register_transaction_master_top.sv
